@@ rtl/core/xet_pkg.sv @@
package xet_pkg;

  localparam int CNT_W = 16;
  localparam int NKW = 21;
  localparam int KEYWORD_MAX_LEN = 22;
  localparam int KW_BITS = KEYWORD_MAX_LEN * 8;
  localparam int MAX_TOK = 3;
  localparam logic [CNT_W-1:0] MAX_EXPR_LEN = 16'hFFFF;
  localparam logic [CNT_W-1:0] MAX_LINE = 16'hFFFF;
  localparam logic [CNT_W-1:0] MAX_COLUMN = 16'hFFFF;
  localparam logic [NKW-1:0] ALL_KW = '1;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_SLASH = 6'd1;
  localparam logic [5:0] K_DSLASH = 6'd2;
  localparam logic [5:0] K_AT = 6'd3;
  localparam logic [5:0] K_DOT = 6'd4;
  localparam logic [5:0] K_DDOT = 6'd5;
  localparam logic [5:0] K_LPAREN = 6'd6;
  localparam logic [5:0] K_RPAREN = 6'd7;
  localparam logic [5:0] K_LBRACKET = 6'd8;
  localparam logic [5:0] K_RBRACKET = 6'd9;
  localparam logic [5:0] K_COMMA = 6'd10;
  localparam logic [5:0] K_DCOLON = 6'd11;
  localparam logic [5:0] K_NCNAME = 6'd12;
  localparam logic [5:0] K_QNAME = 6'd13;
  localparam logic [5:0] K_STRING = 6'd14;
  localparam logic [5:0] K_NUMBER = 6'd15;
  localparam logic [5:0] K_EQ = 6'd16;
  localparam logic [5:0] K_NE = 6'd17;
  localparam logic [5:0] K_LT = 6'd18;
  localparam logic [5:0] K_LE = 6'd19;
  localparam logic [5:0] K_GT = 6'd20;
  localparam logic [5:0] K_GE = 6'd21;
  localparam logic [5:0] K_PLUS = 6'd22;
  localparam logic [5:0] K_MINUS = 6'd23;
  localparam logic [5:0] K_STAR = 6'd24;
  localparam logic [5:0] K_PIPE = 6'd25;
  localparam logic [5:0] K_DOLLAR = 6'd47;
  localparam logic [5:0] K_QUESTION = 6'd48;
  localparam logic [5:0] K_HASH = 6'd49;
  localparam logic [5:0] K_CONCAT = 6'd50;
  localparam logic [5:0] K_COLON = 6'd51;
  localparam logic [5:0] K_ASSIGN = 6'd52;
  localparam logic [5:0] K_ARROW = 6'd53;
  localparam logic [5:0] K_BANG = 6'd54;
  localparam logic [5:0] K_LBRACE = 6'd55;
  localparam logic [5:0] K_RBRACE = 6'd56;

  // bits 0..12 axes, 13..16 node tests, 17..20 operator words
  localparam logic [KW_BITS-1:0] KW_STR [NKW] = '{
    "ancestor", "ancestor-or-self", "attribute", "child", "descendant",
    "descendant-or-self", "following", "following-sibling", "namespace",
    "parent", "preceding", "preceding-sibling", "self",
    "comment", "text", "node", "processing-instruction",
    "and", "or", "div", "mod"
  };
  localparam logic [4:0] KW_LEN [NKW] = '{
    5'd8, 5'd16, 5'd9, 5'd5, 5'd10, 5'd18, 5'd9, 5'd17, 5'd9, 5'd6, 5'd9, 5'd17, 5'd4,
    5'd7, 5'd4, 5'd4, 5'd22,
    5'd3, 5'd2, 5'd3, 5'd3
  };
  localparam logic [5:0] KW_KIND [NKW] = '{
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd46, 6'd45, 6'd26, 6'd27, 6'd28, 6'd29
  };

  typedef enum logic [4:0] {
    M_IDLE, M_SLASH, M_DOT, M_COLON, M_EQ, M_BANG, M_LT, M_GT, M_PIPE,
    M_STRING, M_NUMBER, M_NAME, M_NAME_COLON, M_LOCAL
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [CNT_W-1:0] start_offset;
    logic [CNT_W-1:0] token_length;
    logic [CNT_W-1:0] start_line;
    logic [CNT_W-1:0] start_column;
    logic             lex_error;
    logic             last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0]         cnt;
    tok_t [MAX_TOK-1:0] tok;
  } bundle_t;

endpackage

@@ rtl/core/xet_front.sv @@
module xet_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  xet_pkg::in_t    in_data,
  output logic            bndl_valid,
  output xet_pkg::bundle_t bndl
);
  import xet_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [5:0] kind;
    logic       err;
    mode_t      mode;
    logic       mark;
    logic       dq_set;
    logic       dq;
    logic       name;
  } sb_t;

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_nstart(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_" || b[7];
  endfunction

  function automatic logic is_nchar(logic [7:0] b);
    return is_nstart(b) || is_digit(b) || b == "-" || b == ".";
  endfunction

  function automatic logic [NKW-1:0] kw_match(logic [CNT_W-1:0] n, logic [7:0] b);
    logic [NKW-1:0] m;
    logic [4:0] p;
    m = '0;
    for (int k = 0; k < NKW; k++) begin
      p = 5'(KW_LEN[k] - 5'd1 - n[4:0]);
      if (n < CNT_W'(KW_LEN[k]) && KW_STR[k][{p, 3'b000} +: 8] == b) m[k] = 1'b1;
    end
    return m;
  endfunction

  // sel: 0 operator words only, 1 followed by "::", 2 followed by '('
  function automatic logic [5:0] name_kind(logic [1:0] sel, logic [NKW-1:0] c,
                                           logic [CNT_W-1:0] n);
    logic [5:0] kind;
    kind = K_NCNAME;
    for (int k = NKW - 1; k >= 17; k--)
      if (c[k] && n == CNT_W'(KW_LEN[k])) kind = KW_KIND[k];
    if (sel == 2'd1) begin
      for (int k = 12; k >= 0; k--)
        if (c[k] && n == CNT_W'(KW_LEN[k])) kind = KW_KIND[k];
    end
    if (sel == 2'd2) begin
      for (int k = 16; k >= 13; k--)
        if (c[k] && n == CNT_W'(KW_LEN[k])) kind = KW_KIND[k];
    end
    return kind;
  endfunction

  function automatic sb_t start_byte(logic [7:0] b);
    sb_t s;
    s = '0;
    s.mode = M_IDLE;
    if (!is_ws(b)) begin
      s.emit = 1'b1;
      case (b)
        "@": s.kind = K_AT;
        "(": s.kind = K_LPAREN;
        ")": s.kind = K_RPAREN;
        "[": s.kind = K_LBRACKET;
        "]": s.kind = K_RBRACKET;
        ",": s.kind = K_COMMA;
        "?": s.kind = K_QUESTION;
        "#": s.kind = K_HASH;
        "+": s.kind = K_PLUS;
        "-": s.kind = K_MINUS;
        "*": s.kind = K_STAR;
        "$": s.kind = K_DOLLAR;
        "{": s.kind = K_LBRACE;
        "}": s.kind = K_RBRACE;
        default: begin
          s.emit = 1'b0;
          s.mark = 1'b1;
        end
      endcase
      if (s.mark) begin
        case (b)
          "|": s.mode = M_PIPE;
          "/": s.mode = M_SLASH;
          ".": s.mode = M_DOT;
          ":": s.mode = M_COLON;
          "=": s.mode = M_EQ;
          "!": s.mode = M_BANG;
          "<": s.mode = M_LT;
          ">": s.mode = M_GT;
          "'", "\"": begin
            s.mode = M_STRING;
            s.dq_set = 1'b1;
            s.dq = (b == "\"");
          end
          default: begin
            if (is_digit(b)) begin
              s.mode = M_NUMBER;
            end else if (is_nstart(b)) begin
              s.mode = M_NAME;
              s.name = 1'b1;
            end else begin
              s.emit = 1'b1;
              s.kind = K_END;
              s.err = 1'b1;
            end
          end
        endcase
      end
    end
    return s;
  endfunction

  function automatic tok_t mk(logic [5:0] kind, logic [CNT_W-1:0] off, logic [CNT_W-1:0] len,
                              logic [CNT_W-1:0] line, logic [CNT_W-1:0] col, logic err);
    tok_t t;
    t.token_kind = kind;
    t.start_offset = off;
    t.token_length = len;
    t.start_line = line;
    t.start_column = col;
    t.lex_error = err;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  mode_t mode_r, mode_nxt;
  logic dq_r, dq_nxt, err_r, err_nxt;
  logic [CNT_W-1:0] off_r, off_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [CNT_W-1:0] ts_off_r, ts_off_nxt, ts_line_r, ts_line_nxt, ts_col_r, ts_col_nxt;
  logic [CNT_W-1:0] npl_r, npl_nxt;
  logic [NKW-1:0] kwc_r, kwc_nxt;

  logic [7:0] b;
  logic eot;
  sb_t sb;
  logic [7:0] second;
  logic [5:0] two_kind, one_kind;
  logic [CNT_W-1:0] prev_off, prev_col;

  assign b = in_data.text_byte;
  assign eot = in_data.end_of_text;
  assign sb = start_byte(b);
  assign prev_off = (off_r != '0) ? off_r - 1'b1 : '0;
  assign prev_col = (col_r > CNT_W'(1)) ? col_r - 1'b1 : CNT_W'(1);

  // Second byte and kinds of the pending two-byte operators
  always_comb begin
    second = 8'h00;
    two_kind = K_END;
    one_kind = K_END;
    case (mode_r)
      M_PIPE: begin second = "|"; two_kind = K_CONCAT; one_kind = K_PIPE; end
      M_SLASH: begin second = "/"; two_kind = K_DSLASH; one_kind = K_SLASH; end
      M_DOT: begin second = "."; two_kind = K_DDOT; one_kind = K_DOT; end
      M_COLON: begin
        second = (b == "=") ? 8'h3D : 8'h3A;
        two_kind = (b == "=") ? K_ASSIGN : K_DCOLON;
        one_kind = K_COLON;
      end
      M_EQ: begin second = ">"; two_kind = K_ARROW; one_kind = K_EQ; end
      M_BANG: begin second = "="; two_kind = K_NE; one_kind = K_BANG; end
      M_LT: begin second = "="; two_kind = K_LE; one_kind = K_LT; end
      M_GT: begin second = "="; two_kind = K_GE; one_kind = K_GT; end
      default: ;
    endcase
  end

  // Next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (eot) begin
      mode_nxt = M_IDLE;
    end else if (!err_r) begin
      case (mode_r)
        M_PIPE, M_SLASH, M_COLON, M_EQ, M_BANG, M_LT, M_GT:
          mode_nxt = (b == second) ? M_IDLE : sb.mode;
        M_DOT: mode_nxt = is_digit(b) ? M_NUMBER : (b == second) ? M_IDLE : sb.mode;
        M_STRING: mode_nxt = (b == (dq_r ? 8'h22 : 8'h27)) ? M_IDLE : M_STRING;
        M_NUMBER: mode_nxt = (is_digit(b) || b == ".") ? M_NUMBER : sb.mode;
        M_NAME: mode_nxt = is_nchar(b) ? M_NAME : (b == ":") ? M_NAME_COLON : sb.mode;
        M_NAME_COLON: mode_nxt = (b == ":") ? M_IDLE : is_nstart(b) ? M_LOCAL : sb.mode;
        M_LOCAL: mode_nxt = is_nchar(b) ? M_LOCAL : sb.mode;
        default: mode_nxt = sb.mode;
      endcase
    end
  end

  // Tokens and datapath state
  always_comb begin
    tok_t toks [MAX_TOK];
    logic [1:0] n;
    logic do_sb;
    for (int i = 0; i < MAX_TOK; i++) toks[i] = '0;
    n = 2'd0;
    do_sb = 1'b0;
    dq_nxt = dq_r;
    err_nxt = err_r;
    off_nxt = off_r;
    line_nxt = line_r;
    col_nxt = col_r;
    ts_off_nxt = ts_off_r;
    ts_line_nxt = ts_line_r;
    ts_col_nxt = ts_col_r;
    npl_nxt = npl_r;
    kwc_nxt = kwc_r;
    if (eot) begin
      if (err_r) begin
        toks[n] = mk(K_END, ts_off_r, '0, ts_line_r, ts_col_r, 1'b1); n = n + 2'd1;
      end else if (mode_r == M_STRING) begin
        toks[n] = mk(K_END, ts_off_r, '0, ts_line_r, ts_col_r, 1'b1); n = n + 2'd1;
      end else begin
        case (mode_r)
          M_PIPE, M_SLASH, M_DOT, M_COLON, M_EQ, M_BANG, M_LT, M_GT: begin
            toks[n] = mk(one_kind, ts_off_r, CNT_W'(1), ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
          end
          M_NUMBER, M_LOCAL: begin
            toks[n] = mk((mode_r == M_NUMBER) ? K_NUMBER : K_QNAME, ts_off_r,
                         off_r - ts_off_r, ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
          end
          M_NAME, M_NAME_COLON: begin
            toks[n] = mk(name_kind(2'd0, kwc_r, npl_r), ts_off_r, npl_r, ts_line_r,
                         ts_col_r, 1'b0);
            n = n + 2'd1;
            if (mode_r == M_NAME_COLON) begin
              toks[n] = mk(K_COLON, prev_off, CNT_W'(1), line_r, prev_col, 1'b0);
              n = n + 2'd1;
            end
          end
          default: ;
        endcase
        toks[n] = mk(K_END, off_r, '0, line_r, col_r, 1'b0); n = n + 2'd1;
      end
      // return to the reset state
      dq_nxt = 1'b0;
      err_nxt = 1'b0;
      off_nxt = '0;
      line_nxt = CNT_W'(1);
      col_nxt = CNT_W'(1);
      ts_off_nxt = '0;
      ts_line_nxt = CNT_W'(1);
      ts_col_nxt = CNT_W'(1);
      npl_nxt = '0;
      kwc_nxt = ALL_KW;
    end else if (!err_r) begin
      case (mode_r)
        M_PIPE, M_SLASH, M_COLON, M_EQ, M_BANG, M_LT, M_GT, M_DOT: begin
          if (mode_r == M_DOT && is_digit(b)) begin
            n = 2'd0;
          end else if (b == second) begin
            toks[n] = mk(two_kind, ts_off_r, CNT_W'(2), ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
          end else begin
            toks[n] = mk(one_kind, ts_off_r, CNT_W'(1), ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
            do_sb = 1'b1;
          end
        end
        M_STRING: begin
          if (b == (dq_r ? 8'h22 : 8'h27)) begin
            toks[n] = mk(K_STRING, ts_off_r, off_r - ts_off_r + 1'b1, ts_line_r, ts_col_r,
                         1'b0);
            n = n + 2'd1;
          end
        end
        M_NUMBER, M_LOCAL: begin
          if ((mode_r == M_NUMBER) ? !(is_digit(b) || b == ".") : !is_nchar(b)) begin
            toks[n] = mk((mode_r == M_NUMBER) ? K_NUMBER : K_QNAME, ts_off_r,
                         off_r - ts_off_r, ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
            do_sb = 1'b1;
          end
        end
        M_NAME: begin
          if (is_nchar(b)) begin
            kwc_nxt = kwc_r & kw_match(npl_r, b);
            if (npl_r != '1) npl_nxt = npl_r + 1'b1;
          end else if (b != ":") begin
            toks[n] = mk(name_kind((b == "(") ? 2'd2 : 2'd0, kwc_r, npl_r), ts_off_r, npl_r,
                         ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
            do_sb = 1'b1;
          end
        end
        M_NAME_COLON: begin
          if (b == ":") begin
            toks[n] = mk(name_kind(2'd1, kwc_r, npl_r), ts_off_r, npl_r, ts_line_r, ts_col_r,
                         1'b0);
            n = n + 2'd1;
            toks[n] = mk(K_DCOLON, prev_off, CNT_W'(2), line_r, prev_col, 1'b0);
            n = n + 2'd1;
          end else if (!is_nstart(b)) begin
            // prefix colon dropped silently
            toks[n] = mk(name_kind((b == "(") ? 2'd2 : 2'd0, kwc_r, npl_r), ts_off_r, npl_r,
                         ts_line_r, ts_col_r, 1'b0);
            n = n + 2'd1;
            do_sb = 1'b1;
          end
        end
        default: do_sb = 1'b1;
      endcase
      if (do_sb) begin
        if (sb.mark) begin
          ts_off_nxt = off_r;
          ts_line_nxt = line_r;
          ts_col_nxt = col_r;
        end
        if (sb.dq_set) dq_nxt = sb.dq;
        if (sb.name) begin
          npl_nxt = CNT_W'(1);
          kwc_nxt = kw_match('0, b);
        end
        if (sb.emit) begin
          toks[n] = mk(sb.kind, off_r, sb.err ? '0 : CNT_W'(1), line_r, col_r, sb.err);
          n = n + 2'd1;
        end
        if (sb.err) err_nxt = 1'b1;
      end
      // advance position
      if (off_r < MAX_EXPR_LEN) off_nxt = off_r + 1'b1;
      if (b == 8'h0A) begin
        if (line_r < MAX_LINE) line_nxt = line_r + 1'b1;
        col_nxt = CNT_W'(1);
      end else if (col_r < MAX_COLUMN) begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (n != 2'd0) toks[n - 2'd1].last_of_run = 1'b1;
    bndl.cnt = n;
    for (int i = 0; i < MAX_TOK; i++) bndl.tok[i] = toks[i];
    bndl_valid = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      dq_r <= 1'b0;
      err_r <= 1'b0;
      off_r <= '0;
      line_r <= CNT_W'(1);
      col_r <= CNT_W'(1);
      ts_off_r <= '0;
      ts_line_r <= CNT_W'(1);
      ts_col_r <= CNT_W'(1);
      npl_r <= '0;
      kwc_r <= ALL_KW;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dq_r <= dq_nxt;
      err_r <= err_nxt;
      off_r <= off_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      ts_off_r <= ts_off_nxt;
      ts_line_r <= ts_line_nxt;
      ts_col_r <= ts_col_nxt;
      npl_r <= npl_nxt;
      kwc_r <= kwc_nxt;
    end
  end

endmodule

@@ rtl/core/xet_back.sv @@
module xet_back #(
  parameter int QUEUE_DEPTH = xet_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             bndl_valid,
  input  xet_pkg::bundle_t bndl,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output xet_pkg::tok_t    out_tok
);
  import xet_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t q_mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] q_cnt_r;
  logic [1:0] sel_r;
  logic out_valid_r;
  tok_t out_tok_r;
  bundle_t head;
  logic load, deq;

  assign head = q_mem[rd_ptr_r];
  assign full = (q_cnt_r == CW'(QUEUE_DEPTH));
  // load the output register when it is free or being drained
  assign load = (q_cnt_r != '0) && (!out_valid_r || pop);
  assign deq = load && (sel_r == head.cnt - 2'd1);
  assign empty = !out_valid_r;
  assign out_tok = out_tok_r;

  always_ff @(posedge clk) begin
    if (bndl_valid) q_mem[wr_ptr_r] <= bndl;
    if (load) out_tok_r <= head.tok[sel_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r <= '0;
      sel_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (bndl_valid)
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (deq)
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      q_cnt_r <= q_cnt_r + CW'(bndl_valid) - CW'(deq);
      if (load) sel_r <= deq ? 2'd0 : sel_r + 2'd1;
      if (load) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CW'(QUEUE_DEPTH)) else $error("bundle queue overrun");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !bndl_valid) else $error("bundle written while queue full");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r != '0) |-> (sel_r < head.cnt)) else $error("token index past bundle");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r) else $error("loaded token not shown");
`endif

endmodule

@@ rtl/core/xpath_expression_tokenizer_core.sv @@
// XPath tokenizer: push one byte per transaction (end_of_text=1 closes the
// expression and returns to the reset state). The front lexer takes one byte
// every cycle while the queue has room and turns it into zero to three
// tokens, which go as one bundle into a small bundle queue; the back drains
// that queue one token per cycle while the receiver pops, into the output
// register. Sustained rate is one byte per cycle while the receiver pops and
// each byte yields at most one token; full rises at QUEUE_DEPTH bundles.
module xpath_expression_tokenizer_core #(
  parameter int QUEUE_DEPTH = xet_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  xet_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output xet_pkg::tok_t out_data
);
  import xet_pkg::*;

  logic accept;
  logic bndl_valid;
  bundle_t bndl;

  // accept a byte transaction whenever the bundle queue has room
  assign accept = push && !full;

  xet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .bndl_valid(bndl_valid),
    .bndl      (bndl)
  );

  // hold finished tokens and serialize them to the output port
  xet_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bndl_valid(bndl_valid),
    .bndl      (bndl),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_tok   (out_data)
  );

endmodule

@@ dv/xet_token_checker.sv @@
module xet_token_checker
  import xet_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic full,
  input  in_t  in_data,
  input  logic empty,
  input  logic pop,
  input  tok_t out_data,
  output int   fail_count,
  output int   outstanding
);

  // lexer state mirrored from the block's behavior
  mode_t            mode;
  logic             dq;
  logic [CNT_W-1:0] off, line, col, soff, sline, scol, nlen;
  logic [NKW-1:0]   cand;
  logic             err;

  tok_t run_toks[$];
  tok_t pending_toks[$];

  function automatic bit is_space(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_lead(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_" || b >= 8'h80;
  endfunction

  function automatic bit is_namech(logic [7:0] b);
    return is_lead(b) || is_num(b) || b == "-" || b == ".";
  endfunction

  task automatic clear_state();
    mode = M_IDLE;
    dq = 1'b0;
    off = '0;
    line = 16'd1;
    col = 16'd1;
    soff = '0;
    sline = 16'd1;
    scol = 16'd1;
    nlen = '0;
    cand = ALL_KW;
    err = 1'b0;
  endtask

  task automatic put(logic [5:0] k, logic [15:0] o, logic [15:0] len, logic [15:0] l,
                     logic [15:0] c, logic e);
    tok_t t;
    if (run_toks.size() < MAX_TOK) begin
      t.token_kind = k;
      t.start_offset = o;
      t.token_length = len;
      t.start_line = l;
      t.start_column = c;
      t.lex_error = e;
      t.last_of_run = 1'b0;
      run_toks.push_back(t);
    end
  endtask

  task automatic put_started(logic [5:0] k, logic [15:0] len);
    put(k, soff, len, sline, scol, 1'b0);
  endtask

  task automatic mark_start();
    soff = off;
    sline = line;
    scol = col;
  endtask

  // narrow the keyword candidates by the byte at the current name position
  task automatic feed(logic [7:0] b);
    for (int k = 0; k < NKW; k++) begin
      if (nlen >= KW_LEN[k] || KW_STR[k][(int'(KW_LEN[k]) - 1 - int'(nlen)) * 8 +: 8] != b)
        cand[k] = 1'b0;
    end
    if (nlen != 16'hFFFF) nlen++;
  endtask

  // sel 1: followed by "::" (axes), 2: followed by '(' (node tests), 0: words only
  function automatic logic [5:0] classify(int sel);
    int lo = 17, hi = NKW;
    if (sel == 1) begin lo = 0; hi = 13; end
    if (sel == 2) begin lo = 13; hi = 17; end
    for (int k = lo; k < hi; k++)
      if (cand[k] && nlen == KW_LEN[k]) return KW_KIND[k];
    for (int k = 17; k < NKW; k++)
      if (cand[k] && nlen == KW_LEN[k]) return KW_KIND[k];
    return K_NCNAME;
  endfunction

  task automatic lead(logic [7:0] b);
    logic [5:0] k;
    bit hit;
    mode = M_IDLE;
    hit = 1'b1;
    if (is_space(b)) return;
    case (b)
      "@": k = K_AT;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACKET;
      "]": k = K_RBRACKET;
      ",": k = K_COMMA;
      "?": k = K_QUESTION;
      "#": k = K_HASH;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "$": k = K_DOLLAR;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      default: hit = 1'b0;
    endcase
    if (hit) begin
      put(k, off, 16'd1, line, col, 1'b0);
      return;
    end
    mark_start();
    case (b)
      "|": mode = M_PIPE;
      "/": mode = M_SLASH;
      ".": mode = M_DOT;
      ":": mode = M_COLON;
      "=": mode = M_EQ;
      "!": mode = M_BANG;
      "<": mode = M_LT;
      ">": mode = M_GT;
      "'", "\"": begin
        dq = (b == "\"");
        mode = M_STRING;
      end
      default: begin
        if (is_num(b)) mode = M_NUMBER;
        else if (is_lead(b)) begin
          nlen = '0;
          cand = ALL_KW;
          feed(b);
          mode = M_NAME;
        end else begin
          put(K_END, off, 16'd0, line, col, 1'b1);
          err = 1'b1;
        end
      end
    endcase
  endtask

  task automatic pend(logic [7:0] b, logic [7:0] second, logic [5:0] two, logic [5:0] one);
    if (b == second) begin
      put_started(two, 16'd2);
      mode = M_IDLE;
    end else begin
      put_started(one, 16'd1);
      lead(b);
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    case (mode)
      M_PIPE:  pend(b, "|", K_CONCAT, K_PIPE);
      M_SLASH: pend(b, "/", K_DSLASH, K_SLASH);
      M_DOT:
        if (is_num(b)) mode = M_NUMBER;
        else pend(b, ".", K_DDOT, K_DOT);
      M_COLON:
        if (b == "=") pend(b, "=", K_ASSIGN, K_COLON);
        else pend(b, ":", K_DCOLON, K_COLON);
      M_EQ:    pend(b, ">", K_ARROW, K_EQ);
      M_BANG:  pend(b, "=", K_NE, K_BANG);
      M_LT:    pend(b, "=", K_LE, K_LT);
      M_GT:    pend(b, "=", K_GE, K_GT);
      M_STRING:
        if (b == (dq ? 8'h22 : 8'h27)) begin
          put_started(K_STRING, off - soff + 16'd1);
          mode = M_IDLE;
        end
      M_NUMBER:
        if (!is_num(b) && b != ".") begin
          put_started(K_NUMBER, off - soff);
          lead(b);
        end
      M_NAME:
        if (is_namech(b)) feed(b);
        else if (b == ":") mode = M_NAME_COLON;
        else begin
          put_started(classify(b == "(" ? 2 : 0), nlen);
          lead(b);
        end
      M_NAME_COLON:
        if (b == ":") begin
          put_started(classify(1), nlen);
          put(K_DCOLON, off > 0 ? off - 16'd1 : 16'd0, 16'd2, line,
              col > 1 ? col - 16'd1 : 16'd1, 1'b0);
          mode = M_IDLE;
        end else if (is_lead(b)) begin
          mode = M_LOCAL;
        end else begin
          // prefix colon without a local part is dropped
          put_started(classify(b == "(" ? 2 : 0), nlen);
          lead(b);
        end
      M_LOCAL:
        if (!is_namech(b)) begin
          put_started(K_QNAME, off - soff);
          lead(b);
        end
      default: lead(b);
    endcase
  endtask

  task automatic take_end();
    if (err) begin
      put(K_END, soff, 16'd0, sline, scol, 1'b1);
      clear_state();
      return;
    end
    case (mode)
      M_PIPE:   put_started(K_PIPE, 16'd1);
      M_SLASH:  put_started(K_SLASH, 16'd1);
      M_DOT:    put_started(K_DOT, 16'd1);
      M_COLON:  put_started(K_COLON, 16'd1);
      M_EQ:     put_started(K_EQ, 16'd1);
      M_BANG:   put_started(K_BANG, 16'd1);
      M_LT:     put_started(K_LT, 16'd1);
      M_GT:     put_started(K_GT, 16'd1);
      M_STRING: begin
        // unterminated string: one error K_END token at the opening quote, no plain end token
        put(K_END, soff, 16'd0, sline, scol, 1'b1);
        clear_state();
        return;
      end
      M_NUMBER: put_started(K_NUMBER, off - soff);
      M_NAME:   put_started(classify(0), nlen);
      M_NAME_COLON: begin
        put_started(classify(0), nlen);
        put(K_COLON, off > 0 ? off - 16'd1 : 16'd0, 16'd1, line,
            col > 1 ? col - 16'd1 : 16'd1, 1'b0);
      end
      M_LOCAL:  put_started(K_QNAME, off - soff);
      default: ;
    endcase
    put(K_END, off, 16'd0, line, col, 1'b0);
    clear_state();
  endtask

  task automatic advance(logic [7:0] b);
    if (off < MAX_EXPR_LEN) off++;
    if (b == 8'h0A) begin
      if (line < MAX_LINE) line++;
      col = 16'd1;
    end else if (col < MAX_COLUMN) begin
      col++;
    end
  endtask

  task automatic predict_tokens(in_t x);
    run_toks.delete();
    if (x.end_of_text) take_end();
    else if (!err) begin
      take_byte(x.text_byte);
      advance(x.text_byte);
    end
    if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last_of_run = 1'b1;
    foreach (run_toks[i]) pending_toks.push_back(run_toks[i]);
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
    clear_state();
  end

  always @(posedge clk) begin
    tok_t want;
    if (!rst_n) begin
      clear_state();
      pending_toks.delete();
    end else begin
      if (push && !full) predict_tokens(in_data);
      if (pop && !empty) begin
        if (pending_toks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected token kind=%0d off=%0d len=%0d line=%0d col=%0d err=%0d last=%0d",
                     out_data.token_kind, out_data.start_offset, out_data.token_length,
                     out_data.start_line, out_data.start_column, out_data.lex_error,
                     out_data.last_of_run);
        end else begin
          want = pending_toks.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("token mismatch at %0t", $time);
              $display("  kind %0d/%0d off %0d/%0d len %0d/%0d (expected/actual)",
                       want.token_kind, out_data.token_kind, want.start_offset,
                       out_data.start_offset, want.token_length, out_data.token_length);
              $display("  line %0d/%0d col %0d/%0d err %0d/%0d last %0d/%0d",
                       want.start_line, out_data.start_line, want.start_column,
                       out_data.start_column, want.lex_error, out_data.lex_error,
                       want.last_of_run, out_data.last_of_run);
            end
          end
        end
      end
    end
    outstanding = pending_toks.size();
  end

endmodule

@@ dv/xpath_expression_tokenizer_core_tb.sv @@
module xpath_expression_tokenizer_core_tb;
  import xet_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int RANDOM_ITEMS = 480;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t  in_data = '0;
  logic empty;
  logic pop = 1'b0;
  tok_t out_data;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // sender burst bookkeeping
  int burst_left = 0;
  int bytes_sent = 0;

  // receiver stall pattern: style switches every so often
  int pop_style = 0;
  int pop_style_left = 0;

  // bytes of the expression under construction
  logic [7:0] expr_bytes[$];

  string axis_words[13] = '{"ancestor", "ancestor-or-self", "attribute", "child",
                            "descendant", "descendant-or-self", "following",
                            "following-sibling", "namespace", "parent", "preceding",
                            "preceding-sibling", "self"};
  string test_words[4] = '{"comment", "text", "node", "processing-instruction"};
  string op_words[4] = '{"and", "or", "div", "mod"};
  string pair_ops[10] = '{"//", "..", "::", ":=", "=>", "!=", "<=", ">=", "||", "=="};
  string single_ops = "@()[],?#+-*${}|/.:=!<>";
  string bad_bytes = "%&;^`~\\";

  always #5 clk = ~clk;

  xpath_expression_tokenizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  xet_token_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: end the run as a failure once the cycle count passes CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: always pop, pop half the time, or pop only now and then
  always @(negedge clk) begin
    if (pop_style_left == 0) begin
      pop_style = $urandom_range(0, 2);
      pop_style_left = $urandom_range(8, 120);
    end else begin
      pop_style_left--;
    end
    case (pop_style)
      0: pop <= rst_n;
      1: pop <= rst_n && $urandom_range(0, 1);
      default: pop <= rst_n && ($urandom_range(0, 5) == 0);
    endcase
  end

  // Drive one transaction, called at a falling edge. full only moves at the rising
  // edge, so its value here holds through the edge that takes the item.
  task automatic send(logic [7:0] b, logic eot);
    in_t x;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    x.text_byte = b;
    x.end_of_text = eot;
    push <= 1'b1;
    in_data <= x;
    while (full) @(negedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
  endtask

  // send the collected bytes, then close the expression with a junk byte beside it
  task automatic flush_expr();
    foreach (expr_bytes[i]) send(expr_bytes[i], 1'b0);
    expr_bytes.delete();
    send(8'($urandom), 1'b1);
  endtask

  task automatic run_expr(string s);
    add_str(s);
    flush_expr();
  endtask

  function automatic logic [7:0] rand_lead();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return "_";
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_namech();
    case ($urandom_range(0, 5))
      0: return "-";
      1: return ".";
      2: return 8'($urandom_range("0", "9"));
      default: return rand_lead();
    endcase
  endfunction

  task automatic add_name();
    expr_bytes.push_back(rand_lead());
    repeat ($urandom_range(0, 6)) expr_bytes.push_back(rand_namech());
  endtask

  task automatic add_space();
    string ws = " \t\n\v\f\r";
    repeat ($urandom_range(1, 3)) expr_bytes.push_back(ws[$urandom_range(0, 5)]);
  endtask

  // one well-formed piece of an expression, mostly; some noise now and then
  task automatic add_fragment();
    string q;
    case ($urandom_range(0, 15))
      0, 1: add_name();
      2: add_str({axis_words[$urandom_range(0, 12)], "::"});
      3: add_str({test_words[$urandom_range(0, 3)], "("});
      4: add_str(op_words[$urandom_range(0, 3)]);
      5: begin
        add_name();
        expr_bytes.push_back(":");
        add_name();
      end
      6: begin
        q = $urandom_range(0, 1) ? "\"" : "'";
        add_str(q);
        repeat ($urandom_range(0, 5)) expr_bytes.push_back(8'($urandom_range(8'h20, 8'hFF)));
        if ($urandom_range(0, 7) != 0) add_str(q);
      end
      7: begin
        if ($urandom_range(0, 2) == 0) expr_bytes.push_back(".");
        repeat ($urandom_range(1, 5))
          expr_bytes.push_back($urandom_range(0, 3) ? 8'($urandom_range("0", "9")) : ".");
      end
      8: add_str(pair_ops[$urandom_range(0, 9)]);
      9, 10: expr_bytes.push_back(single_ops[$urandom_range(0, single_ops.len() - 1)]);
      11, 12: add_space();
      13: begin
        // name, colon, then whatever follows
        add_name();
        expr_bytes.push_back(":");
        if ($urandom_range(0, 1)) expr_bytes.push_back(8'($urandom));
      end
      14: expr_bytes.push_back(8'($urandom));
      default: begin
        if ($urandom_range(0, 3) == 0)
          expr_bytes.push_back(bad_bytes[$urandom_range(0, bad_bytes.len() - 1)]);
        else add_space();
      end
    endcase
  endtask

  initial begin
    int guard;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed expressions covering operators, keywords and the corner cases
    run_expr("child::node()");
    run_expr("ancestor-or-self::processing-instruction(");
    run_expr("a:b p:( x:1 comment (");
    run_expr("x:");
    run_expr(".5 1.2.3 . .. 7");
    run_expr("'ab\"c' \"q'\"");
    run_expr("//@*[a!=b<=c>=d||e:=f=>g]");
    run_expr("|/.:=!<>$?#{},+-");
    run_expr("div mod and or andx");
    run_expr("'open");
    run_expr("a % b c");
    run_expr(" \t\n\v\f\r");
    expr_bytes.push_back(8'hFF);
    expr_bytes.push_back(8'h80);
    expr_bytes.push_back(8'h00);
    flush_expr();
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);

    // random expressions until the item budget is spent
    while (bytes_sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 12)) begin
        add_fragment();
        if ($urandom_range(0, 2) == 0) add_space();
      end
      flush_expr();
    end

    push <= 1'b0;
    // drain whatever is still owed, then let the block settle
    guard = 0;
    while (outstanding != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/xet_pkg.sv
rtl/core/xet_front.sv
rtl/core/xet_back.sv
rtl/core/xpath_expression_tokenizer_core.sv
dv/xet_token_checker.sv
dv/xpath_expression_tokenizer_core_tb.sv
